>>> rtl/sfeq_pkg.sv
// shared types, constants and helpers of the stereo q15 fir equalizer
`timescale 1ns / 1ps
`default_nettype none
package sfeq_pkg;

	localparam int TAPS = 81;
	localparam int BANKS = 3;
	localparam int TAP_W = (TAPS > 1) ? $clog2(TAPS) : 1;
	localparam int FILL_W = $clog2(TAPS + 1);
	localparam int COEF_AW = $clog2(BANKS * TAPS);
	localparam int SW_W = 4;
	localparam int SAMPLE_W = 16;
	localparam int PROD_W = 32;
	localparam int ACC_W = 40;
	localparam int ROUND_HALF = 16384;
	localparam int FRAC_W = 15;
	localparam int SH_W = ACC_W - FRAC_W;
	localparam int QDEPTH = 2;
	localparam int QAW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

	// coefficient bank codes
	localparam logic [1:0] BANK_LOW = 2'd0;
	localparam logic [1:0] BANK_BAND = 2'd1;
	localparam logic [1:0] BANK_HIGH = 2'd2;

	typedef enum logic {
		OP_SAMPLE = 1'b0,
		OP_LOAD = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		MODE_BYPASS,
		MODE_LOW,
		MODE_BAND,
		MODE_HIGH,
		MODE_MUTE
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAC,
		ST_DRAIN,
		ST_ROUND,
		ST_SHIFT,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic operation;
		logic signed [SAMPLE_W-1:0] left_sample;
		logic signed [SAMPLE_W-1:0] right_sample;
		logic [1:0] coef_bank;
		logic [6:0] coef_index;
		logic signed [SAMPLE_W-1:0] coef_value;
	} in_item_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] left_out;
		logic signed [SAMPLE_W-1:0] right_out;
	} out_item_t;

	// classified command handed from front to back
	typedef struct packed {
		op_t op;
		logic signed [SAMPLE_W-1:0] left;
		logic signed [SAMPLE_W-1:0] right;
		logic [COEF_AW-1:0] coef_addr;
		logic signed [SAMPLE_W-1:0] coef_value;
	} cmd_t;

	function automatic mode_t pick_mode(logic [SW_W-1:0] sw);
		mode_t m;
		if (sw[0]) m = MODE_BYPASS;
		else if (sw[1]) m = MODE_LOW;
		else if (sw[2]) m = MODE_BAND;
		else if (sw[3]) m = MODE_HIGH;
		else m = MODE_MUTE;
		return m;
	endfunction

	function automatic logic [COEF_AW-1:0] bank_base(logic [1:0] bank);
		logic [COEF_AW-1:0] b;
		case (bank)
			BANK_LOW: b = '0;
			BANK_BAND: b = COEF_AW'(TAPS);
			BANK_HIGH: b = COEF_AW'(2 * TAPS);
			default: b = '0;
		endcase
		return b;
	endfunction

endpackage
`default_nettype wire

>>> rtl/sfeq_front.sv
// front stage: accepts items, drops bad coefficient loads, forms commands
`timescale 1ns / 1ps
`default_nettype none
module sfeq_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire sfeq_pkg::in_item_t in_data,
	output logic cmd_valid,
	input wire logic cmd_ready,
	output sfeq_pkg::cmd_t cmd
);
	import sfeq_pkg::*;

	logic load_ok;
	logic keep;
	logic hold_v_q;
	cmd_t hold_q;
	cmd_t cmd_new;

	// loads to bank 3 or past the last tap are swallowed
	assign load_ok = (in_data.coef_bank == BANK_LOW || in_data.coef_bank == BANK_BAND ||
		in_data.coef_bank == BANK_HIGH) && ({2'b00, in_data.coef_index} < 9'(TAPS));
	assign keep = (in_data.operation == OP_SAMPLE) || load_ok;

	always_comb begin
		cmd_new.op = op_t'(in_data.operation);
		cmd_new.left = in_data.left_sample;
		cmd_new.right = in_data.right_sample;
		cmd_new.coef_addr = bank_base(in_data.coef_bank) + COEF_AW'(in_data.coef_index);
		cmd_new.coef_value = in_data.coef_value;
	end

	assign in_ready = !hold_v_q || cmd_ready;
	assign cmd_valid = hold_v_q;
	assign cmd = hold_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q <= 1'b0;
		end else if (in_valid && in_ready) begin
			hold_v_q <= keep;
		end else if (cmd_ready) begin
			hold_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready && keep) begin
			hold_q <= cmd_new;
		end
	end

endmodule
`default_nettype wire

>>> rtl/sfeq_queue.sv
// short command queue between front and back
`timescale 1ns / 1ps
`default_nettype none
module sfeq_queue (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push_valid,
	output logic push_ready,
	input wire sfeq_pkg::cmd_t push_cmd,
	output logic pop_valid,
	input wire logic pop_ready,
	output sfeq_pkg::cmd_t pop_cmd
);
	import sfeq_pkg::*;

	cmd_t entry_q [QDEPTH];
	logic [QAW-1:0] wr_q;
	logic [QAW-1:0] rd_q;
	logic [QAW:0] cnt_q;
	logic push;
	logic pop;

	assign push_ready = cnt_q != (QAW + 1)'(QDEPTH);
	assign pop_valid = cnt_q != '0;
	assign pop_cmd = entry_q[rd_q];
	assign push = push_valid && push_ready;
	assign pop = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == QAW'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == QAW'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= push_cmd;
		end
	end

endmodule
`default_nettype wire

>>> rtl/sfeq_back.sv
// back end: delay lines, coefficient memory, dual mac sequencer, output register
`timescale 1ns / 1ps
`default_nettype none
module sfeq_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cmd_valid,
	output logic cmd_ready,
	input wire sfeq_pkg::cmd_t cmd,
	input wire logic [sfeq_pkg::SW_W-1:0] switch_bits,
	output logic out_valid,
	input wire logic out_ready,
	output sfeq_pkg::out_item_t out_pair
);
	import sfeq_pkg::*;

	function automatic logic signed [PROD_W-1:0] q15_mul(
		logic signed [SAMPLE_W-1:0] a, logic signed [SAMPLE_W-1:0] b);
		logic signed [PROD_W-1:0] p;
		p = a * b;
		// only full-scale negative squared overflows when doubled
		if (p == 32'sh4000_0000) return 32'sh7fff_ffff;
		return p <<< 1;
	endfunction

	function automatic logic signed [ACC_W-1:0] sat_acc(logic signed [ACC_W:0] v);
		logic signed [ACC_W-1:0] r;
		if (v[ACC_W] != v[ACC_W-1]) begin
			r = v[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
		end else begin
			r = v[ACC_W-1:0];
		end
		return r;
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] out_sat(logic signed [ACC_W-1:0] a);
		logic signed [SH_W-1:0] sh;
		logic signed [SAMPLE_W-1:0] r;
		sh = a[ACC_W-1:FRAC_W];
		if ((&sh[SH_W-1:SAMPLE_W-1]) || !(|sh[SH_W-1:SAMPLE_W-1])) begin
			r = sh[SAMPLE_W-1:0];
		end else begin
			r = sh[SH_W-1] ? 16'sh8000 : 16'sh7fff;
		end
		return r;
	endfunction

	function automatic logic signed [ACC_W-1:0] round_acc(logic signed [ACC_W-1:0] a);
		logic signed [ACC_W:0] e;
		e = (ACC_W + 1)'(a);
		if (a >= 0) e = e + (ACC_W + 1)'(ROUND_HALF);
		else e = e - (ACC_W + 1)'(ROUND_HALF);
		return sat_acc(e);
	endfunction

	state_t state_q, state_d;
	mode_t mode_now;

	logic signed [SAMPLE_W-1:0] hist_l_mem [TAPS];
	logic signed [SAMPLE_W-1:0] hist_r_mem [TAPS];
	logic signed [SAMPLE_W-1:0] coef_mem [BANKS * TAPS];
	logic signed [SAMPLE_W-1:0] hist_l_rd_q, hist_r_rd_q, coef_rd_q;

	logic [TAP_W-1:0] wp_q, wp_next, rd_ptr_q, tap_q;
	logic [FILL_W-1:0] fill_q;
	logic [COEF_AW-1:0] coef_base_q, coef_base_new, coef_rd_addr;

	logic start_sample, start_load, issue, last_issue, mask_tap, out_free;

	logic rd_v_s1, rd_last_s1, rd_mask_s1;
	logic prod_v_s2, prod_last_s2;
	logic signed [PROD_W-1:0] prod_l_s2, prod_r_s2;
	logic signed [ACC_W-1:0] acc_l_q, acc_r_q;
	logic signed [SAMPLE_W-1:0] res_l_q, res_r_q;
	logic out_valid_q;
	out_item_t out_q;

	assign mode_now = pick_mode(switch_bits);
	assign cmd_ready = state_q == ST_IDLE;
	assign start_sample = cmd_valid && cmd_ready && cmd.op == OP_SAMPLE;
	assign start_load = cmd_valid && cmd_ready && cmd.op == OP_LOAD;
	assign wp_next = (wp_q == '0) ? TAP_W'(TAPS - 1) : wp_q - 1'b1;
	assign issue = state_q == ST_MAC;
	assign last_issue = issue && tap_q == TAP_W'(TAPS - 1);
	assign mask_tap = FILL_W'(tap_q) >= fill_q;
	assign coef_rd_addr = coef_base_q + COEF_AW'(tap_q);
	assign out_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_pair = out_q;

	always_comb begin
		case (mode_now)
			MODE_LOW: coef_base_new = bank_base(BANK_LOW);
			MODE_BAND: coef_base_new = bank_base(BANK_BAND);
			MODE_HIGH: coef_base_new = bank_base(BANK_HIGH);
			default: coef_base_new = '0;
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start_sample) begin
					if (mode_now == MODE_BYPASS || mode_now == MODE_MUTE) state_d = ST_FINISH;
					else state_d = ST_MAC;
				end
			end
			ST_MAC: begin
				if (last_issue) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (prod_v_s2 && prod_last_s2) state_d = ST_ROUND;
			end
			ST_ROUND: state_d = ST_SHIFT;
			ST_SHIFT: state_d = ST_FINISH;
			ST_FINISH: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			wp_q <= '0;
			fill_q <= '0;
			rd_v_s1 <= 1'b0;
			prod_v_s2 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_v_s1 <= issue;
			prod_v_s2 <= rd_v_s1;
			if (start_sample) begin
				wp_q <= wp_next;
				if (fill_q != FILL_W'(TAPS)) fill_q <= fill_q + 1'b1;
			end
			if (state_q == ST_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// delay lines, newest sample at wp_q, tap j at wp_q + j
	always_ff @(posedge clk) begin
		if (start_sample) begin
			hist_l_mem[wp_next] <= cmd.left;
			hist_r_mem[wp_next] <= cmd.right;
		end
		hist_l_rd_q <= hist_l_mem[rd_ptr_q];
		hist_r_rd_q <= hist_r_mem[rd_ptr_q];
	end

	always_ff @(posedge clk) begin
		if (start_load) begin
			coef_mem[cmd.coef_addr] <= cmd.coef_value;
		end
		coef_rd_q <= coef_mem[coef_rd_addr];
	end

	always_ff @(posedge clk) begin
		if (start_sample) begin
			rd_ptr_q <= wp_next;
			tap_q <= '0;
			coef_base_q <= coef_base_new;
		end else if (issue) begin
			rd_ptr_q <= (rd_ptr_q == TAP_W'(TAPS - 1)) ? '0 : rd_ptr_q + 1'b1;
			tap_q <= tap_q + 1'b1;
		end
		rd_last_s1 <= last_issue;
		rd_mask_s1 <= mask_tap;
		prod_last_s2 <= rd_last_s1;
		// taps past the fill count are forced to zero products
		prod_l_s2 <= rd_mask_s1 ? '0 : q15_mul(hist_l_rd_q, coef_rd_q);
		prod_r_s2 <= rd_mask_s1 ? '0 : q15_mul(hist_r_rd_q, coef_rd_q);
	end

	always_ff @(posedge clk) begin
		if (start_sample) begin
			acc_l_q <= '0;
			acc_r_q <= '0;
		end else if (prod_v_s2) begin
			acc_l_q <= sat_acc((ACC_W + 1)'(acc_l_q) + (ACC_W + 1)'(prod_l_s2));
			acc_r_q <= sat_acc((ACC_W + 1)'(acc_r_q) + (ACC_W + 1)'(prod_r_s2));
		end else if (state_q == ST_ROUND) begin
			acc_l_q <= round_acc(acc_l_q);
			acc_r_q <= round_acc(acc_r_q);
		end
	end

	always_ff @(posedge clk) begin
		if (start_sample) begin
			res_l_q <= (mode_now == MODE_BYPASS) ? cmd.left : '0;
			res_r_q <= (mode_now == MODE_BYPASS) ? cmd.right : '0;
		end else if (state_q == ST_SHIFT) begin
			res_l_q <= out_sat(acc_l_q);
			res_r_q <= out_sat(acc_r_q);
		end
		if (state_q == ST_FINISH && out_free) begin
			out_q.left_out <= res_l_q;
			out_q.right_out <= res_r_q;
		end
	end

endmodule
`default_nettype wire

>>> rtl/stereo_fir_equalizer_q15.sv
// top level of the stereo q15 fir equalizer
// Stereo Q15 FIR equalizer. Each input transfer is either a stereo sample pair or
// a coefficient load into one of three banks (low, band, high pass) of TAPS words;
// a load returns nothing, a bank of 3 or an index of TAPS or more is dropped, and
// all coefficients of the selected bank must be loaded before samples are sent.
// Every sample pair enters both delay lines and returns one output transfer: bypass,
// low, band or high pass as picked by the lowest set bit of switch_bits, or zero
// when no bit is set. Filtering uses saturating doubled Q15 products, a 40-bit
// saturating accumulator, then adds half an output LSB to sums of zero or more or
// subtracts it from negative ones, truncates and saturates to 16 bits. A filtered
// pair holds the back end for one multiply-accumulate per tap per channel through
// the single read port of the delay-line and coefficient memories; bypass or mute
// pairs skip the multiply-accumulate sequence. The front stage and a two-entry
// command queue keep taking transfers while the back end works or the output
// waits. switch_bits is written through the cfg channel; the user must write it
// only while the block is idle, as the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none
module stereo_fir_equalizer_q15 (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire sfeq_pkg::in_item_t in_data,
	output logic out_valid,
	input wire logic out_ready,
	output sfeq_pkg::out_item_t out_pair,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [sfeq_pkg::SW_W-1:0] cfg_data
);
	import sfeq_pkg::*;

	// mode switch register
	logic [SW_W-1:0] switch_q;

	// front to queue
	logic fq_valid, fq_ready;
	cmd_t fq_cmd;

	// queue to back
	logic qb_valid, qb_ready;
	cmd_t qb_cmd;

	// config writes are always accepted and land in the next cycle
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			switch_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			switch_q <= cfg_data;
		end
	end

	// classify and hold one command
	sfeq_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.cmd_valid(fq_valid),
		.cmd_ready(fq_ready),
		.cmd(fq_cmd)
	);

	// decouples front from the long mac sequence
	sfeq_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(fq_valid),
		.push_ready(fq_ready),
		.push_cmd(fq_cmd),
		.pop_valid(qb_valid),
		.pop_ready(qb_ready),
		.pop_cmd(qb_cmd)
	);

	// memories, mac pipeline and output register
	sfeq_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(qb_valid),
		.cmd_ready(qb_ready),
		.cmd(qb_cmd),
		.switch_bits(switch_q),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_pair(out_pair)
	);

endmodule
`default_nettype wire
